/* rtl/adaptive_concurrency_throttle_assert.svh */
// Assertion macros for the adaptive concurrency throttle.
// Included by the top level; needs no package.
`ifndef ADAPTIVE_CONCURRENCY_THROTTLE_ASSERT_SVH
`define ADAPTIVE_CONCURRENCY_THROTTLE_ASSERT_SVH

// same-cycle implication
`define ACT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ACT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/act_pkg.sv */
// Shared constants and types of the adaptive concurrency throttle.
// No dependencies; used by the top level and the testbench.
package act_pkg;

   localparam int NUM_TYPES = 16;
   localparam int TYPE_BITS = $clog2(NUM_TYPES);
   localparam int TIME_BITS = 32;

   localparam logic [1:0] FN_REPORT   = 2'd0;
   localparam logic [1:0] FN_DISPATCH = 2'd1;
   localparam logic [1:0] FN_COMPLETE = 2'd2;
   localparam logic [1:0] FN_TICK     = 2'd3;

   localparam logic [1:0] ADJ_NONE  = 2'd0;
   localparam logic [1:0] ADJ_RAISE = 2'd1;
   localparam logic [1:0] ADJ_LOWER = 2'd2;

   localparam int          CSR_IDX_BITS = 4;
   localparam int          CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ENABLE_MASK   = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SUCCESS_THR   = 4'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INCREASE_RATE = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECREASE_RATE = 4'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_LIMIT     = 4'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_LIMIT     = 4'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COOLDOWN      = 4'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INITIAL_LIMIT = 4'd7;

   localparam logic [15:0] RST_ENABLE_MASK   = 16'd0;
   localparam logic [7:0]  RST_SUCCESS_THR   = 8'd5;
   localparam logic [9:0]  RST_INCREASE_RATE = 10'd384;
   localparam logic [7:0]  RST_DECREASE_RATE = 8'd128;
   localparam logic [7:0]  RST_MIN_LIMIT     = 8'd1;
   localparam logic [7:0]  RST_MAX_LIMIT     = 8'd20;
   localparam logic [15:0] RST_COOLDOWN      = 16'd5000;
   localparam logic [7:0]  RST_INITIAL_LIMIT = 8'd5;

   localparam logic [10:0] RATE_CODE  = 11'd429;
   localparam logic [7:0]  FAIL_RUN   = 8'd3;
   localparam logic [7:0]  RATE_STEP  = 8'd26;
   localparam logic [7:0]  RATE_FLOOR = 8'd128;
   localparam logic [7:0]  COUNT_MAX  = 8'd255;

   typedef struct packed {
      logic [TIME_BITS-1:0] last_time;
      logic                 adj_valid;
      logic [7:0]           decrease_rate;
      logic [7:0]           failure_streak;
      logic [7:0]           success_streak;
      logic [7:0]           limit;
      logic [7:0]           running;
   } entry_type;

endpackage

/* rtl/adaptive_concurrency_throttle.sv */
// Adaptive concurrency throttle top level: per-type limit table and control.
// Depends on act_pkg, act_ram and adaptive_concurrency_throttle_assert.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | func, task_type, success, error_code
//   rsp     | out       | rsp_valid/ready    | granted, current_limit, running_count, adjustment
//   csr     | in        | csr_valid/ready    | csr_index, csr_wdata
//
// Each request does the table read on acceptance, then one
// read-modify-write through the single shared multiplier.
// A result waits in the output register; the write-back stalls while it is held.
// Reset is synchronous; per-entry valid bits stand in for the table reset,
// so no clearing pass is needed. csr writes are always ready.
module adaptive_concurrency_throttle
   import act_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_func,
   input  logic [3:0]               req_task_type,
   input  logic                     req_success,
   input  logic signed [10:0]       req_error_code,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_granted,
   output logic [7:0]               rsp_current_limit,
   output logic [7:0]               rsp_running_count,
   output logic [1:0]               rsp_adjustment,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type            state_ff, state_in;
   logic [15:0]          enable_mask_ff, enable_mask_in;
   logic [7:0]           thr_ff, thr_in;
   logic [9:0]           inc_rate_ff, inc_rate_in;
   logic [7:0]           dec_start_ff, dec_start_in;
   logic [7:0]           min_limit_ff, min_limit_in;
   logic [7:0]           max_limit_ff, max_limit_in;
   logic [15:0]          cooldown_ff, cooldown_in;
   logic [7:0]           init_limit_ff, init_limit_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [NUM_TYPES-1:0] entry_vld_ff, entry_vld_in;
   logic [NUM_TYPES-1:0] limit_vld_ff, limit_vld_in;
   logic [NUM_TYPES-1:0] rate_vld_ff, rate_vld_in;
   logic [1:0]           func_ff, func_in;
   logic [3:0]           type_ff, type_in;
   logic                 success_ff, success_in;
   logic [10:0]          code_ff, code_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 granted_ff, granted_in;
   logic [7:0]           limit_out_ff, limit_out_in;
   logic [7:0]           running_out_ff, running_out_in;
   logic [1:0]           adj_ff, adj_in;

   logic                 req_accept, csr_accept, out_free, in_range, enabled, cooling;
   logic                 ram_we;
   logic [TYPE_BITS-1:0] idx;
   entry_type            ram_rdata, cur, nxt;
   logic [9:0]           mul_b;
   logic [17:0]          product;
   logic [9:0]           scaled;
   logic [7:0]           up_limit, down_limit, ss_inc, fs_inc;
   logic                 result_granted;
   logic [1:0]           result_adj;
   logic [TIME_BITS-1:0] since_adjust;

   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && req_ready;
   assign csr_accept = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign idx      = TYPE_BITS'(type_ff);
   assign in_range = (32'(type_ff) < NUM_TYPES);
   assign enabled  = enable_mask_ff[type_ff];
   assign ram_we   = (state_ff == ST_EXEC) && out_free && in_range;

   act_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (NUM_TYPES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx),
      .wr_data (nxt),
      .rd_en   (req_accept),
      .rd_addr (TYPE_BITS'(req_task_type)),
      .rd_data (ram_rdata)
   );

   // unwritten entries read as reset state; a limit or rate CSR load resets only that field
   always_comb begin
      cur = ram_rdata;
      if (!entry_vld_ff[idx]) begin
         cur.running        = '0;
         cur.success_streak = '0;
         cur.failure_streak = '0;
         cur.adj_valid      = 1'b0;
         cur.last_time      = '0;
      end
      if (!limit_vld_ff[idx]) begin
         cur.limit = init_limit_ff;
      end
      if (!rate_vld_ff[idx]) begin
         cur.decrease_rate = dec_start_ff;
      end
   end

   assign mul_b        = success_ff ? inc_rate_ff : {2'b00, cur.decrease_rate};
   assign product      = {10'd0, cur.limit} * {8'd0, mul_b};
   assign scaled       = product[17:8];
   assign up_limit     = (scaled > {2'b00, max_limit_ff}) ? max_limit_ff : scaled[7:0];
   assign down_limit   = (scaled[7:0] < min_limit_ff) ? min_limit_ff : scaled[7:0];
   assign ss_inc       = (cur.success_streak == COUNT_MAX) ? COUNT_MAX : cur.success_streak + 8'd1;
   assign fs_inc       = (cur.failure_streak == COUNT_MAX) ? COUNT_MAX : cur.failure_streak + 8'd1;
   assign since_adjust = now_ff - cur.last_time;
   assign cooling      = cur.adj_valid && (since_adjust < TIME_BITS'(cooldown_ff));

   always_comb begin
      nxt            = cur;
      result_granted = 1'b0;
      result_adj     = ADJ_NONE;
      case (func_ff)
         FN_REPORT: begin
            if (enabled && !cooling) begin
               if (success_ff) begin
                  nxt.failure_streak = '0;
                  nxt.success_streak = ss_inc;
                  if (ss_inc >= thr_ff && cur.limit < max_limit_ff && up_limit > cur.limit) begin
                     nxt.limit          = up_limit;
                     nxt.success_streak = '0;
                     nxt.last_time      = now_ff;
                     nxt.adj_valid      = 1'b1;
                     result_adj         = ADJ_RAISE;
                  end
               end else if (code_ff != RATE_CODE) begin
                  nxt.failure_streak = '0;
               end else begin
                  nxt.success_streak = '0;
                  nxt.failure_streak = fs_inc;
                  if (down_limit < cur.limit) begin
                     nxt.limit     = down_limit;
                     nxt.last_time = now_ff;
                     nxt.adj_valid = 1'b1;
                     result_adj    = ADJ_LOWER;
                     if (fs_inc >= FAIL_RUN) begin
                        nxt.decrease_rate = (cur.decrease_rate >= RATE_FLOOR + RATE_STEP) ?
                                            cur.decrease_rate - RATE_STEP : RATE_FLOOR;
                     end
                  end
               end
            end
         end
         FN_DISPATCH: begin
            if (!enabled || cur.running < cur.limit) begin
               result_granted = 1'b1;
               nxt.running    = (cur.running == COUNT_MAX) ? COUNT_MAX : cur.running + 8'd1;
            end
         end
         FN_COMPLETE: begin
            if (cur.running != 8'd0) begin
               nxt.running = cur.running - 8'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      enable_mask_in = enable_mask_ff;
      thr_in         = thr_ff;
      inc_rate_in    = inc_rate_ff;
      dec_start_in   = dec_start_ff;
      min_limit_in   = min_limit_ff;
      max_limit_in   = max_limit_ff;
      cooldown_in    = cooldown_ff;
      init_limit_in  = init_limit_ff;
      now_in         = now_ff;
      entry_vld_in   = entry_vld_ff;
      limit_vld_in   = limit_vld_ff;
      rate_vld_in    = rate_vld_ff;
      func_in        = func_ff;
      type_in        = type_ff;
      success_in     = success_ff;
      code_in        = code_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      granted_in     = granted_ff;
      limit_out_in   = limit_out_ff;
      running_out_in = running_out_ff;
      adj_in         = adj_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in    = req_func;
               type_in    = req_task_type;
               success_in = req_success;
               code_in    = req_error_code;
               if (req_func == FN_TICK) begin
                  now_in = now_ff + TIME_BITS'(1);
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (in_range) begin
                  granted_in          = result_granted;
                  limit_out_in        = nxt.limit;
                  running_out_in      = nxt.running;
                  adj_in              = result_adj;
                  entry_vld_in[idx]   = 1'b1;
                  limit_vld_in[idx]   = 1'b1;
                  rate_vld_in[idx]    = 1'b1;
               end else begin
                  granted_in     = 1'b0;
                  limit_out_in   = '0;
                  running_out_in = '0;
                  adj_in         = ADJ_NONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_accept) begin
         case (csr_index)
            CSR_ENABLE_MASK:   enable_mask_in = csr_wdata;
            CSR_SUCCESS_THR:   thr_in         = csr_wdata[7:0];
            CSR_INCREASE_RATE: inc_rate_in    = csr_wdata[9:0];
            CSR_DECREASE_RATE: begin
               dec_start_in = csr_wdata[7:0];
               rate_vld_in  = '0;
            end
            CSR_MIN_LIMIT:     min_limit_in   = csr_wdata[7:0];
            CSR_MAX_LIMIT:     max_limit_in   = csr_wdata[7:0];
            CSR_COOLDOWN:      cooldown_in    = csr_wdata;
            CSR_INITIAL_LIMIT: begin
               init_limit_in = csr_wdata[7:0];
               limit_vld_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         enable_mask_ff <= RST_ENABLE_MASK;
         thr_ff         <= RST_SUCCESS_THR;
         inc_rate_ff    <= RST_INCREASE_RATE;
         dec_start_ff   <= RST_DECREASE_RATE;
         min_limit_ff   <= RST_MIN_LIMIT;
         max_limit_ff   <= RST_MAX_LIMIT;
         cooldown_ff    <= RST_COOLDOWN;
         init_limit_ff  <= RST_INITIAL_LIMIT;
         now_ff         <= '0;
         entry_vld_ff   <= '0;
         limit_vld_ff   <= '0;
         rate_vld_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         enable_mask_ff <= enable_mask_in;
         thr_ff         <= thr_in;
         inc_rate_ff    <= inc_rate_in;
         dec_start_ff   <= dec_start_in;
         min_limit_ff   <= min_limit_in;
         max_limit_ff   <= max_limit_in;
         cooldown_ff    <= cooldown_in;
         init_limit_ff  <= init_limit_in;
         now_ff         <= now_in;
         entry_vld_ff   <= entry_vld_in;
         limit_vld_ff   <= limit_vld_in;
         rate_vld_ff    <= rate_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      func_ff        <= func_in;
      type_ff        <= type_in;
      success_ff     <= success_in;
      code_ff        <= code_in;
      granted_ff     <= granted_in;
      limit_out_ff   <= limit_out_in;
      running_out_ff <= running_out_in;
      adj_ff         <= adj_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = granted_ff;
   assign rsp_current_limit = limit_out_ff;
   assign rsp_running_count = running_out_ff;
   assign rsp_adjustment    = adj_ff;

`include "adaptive_concurrency_throttle_assert.svh"

   `ACT_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_accept, state_ff == ST_EXEC, "no execute")
   `ACT_ASSERT_NOW(a_no_write_when_held, clock, reset, !out_free, !ram_we, "write while held")
   `ACT_ASSERT_NOW(a_grant_run, clock, reset, rsp_valid && granted_ff, running_out_ff != '0, "no count")
   `ACT_ASSERT_NOW(a_adj_code, clock, reset, rsp_valid, rsp_adjustment <= ADJ_LOWER, "bad adjustment")

endmodule

/* rtl/act_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module act_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sim/adaptive_concurrency_throttle_tb.sv */
// Self-checking testbench for adaptive_concurrency_throttle: request driver,
// response sink with random back-pressure, and a scoreboard that predicts every response.
// Depends on act_pkg and the adaptive_concurrency_throttle RTL.
module adaptive_concurrency_throttle_tb
   import act_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS = 80;
   localparam int NUM_PHASES  = 6;
   localparam int FLOOD_ITEMS = 258;

   typedef struct packed {
      logic       granted;
      logic [7:0] cur_limit;
      logic [7:0] run_count;
      logic [1:0] adj;
   } throttle_rsp_type;

   class throttle_tracker;
      logic [15:0] enable_mask;
      logic [7:0]  success_thr;
      logic [9:0]  inc_rate;
      logic [7:0]  dec_start;
      logic [7:0]  min_lim;
      logic [7:0]  max_lim;
      logic [15:0] cooldown;
      logic [7:0]  init_lim;

      logic [7:0]  run_cnt [NUM_TYPES];
      logic [7:0]  lim [NUM_TYPES];
      logic [7:0]  succ_streak [NUM_TYPES];
      logic [7:0]  fail_streak [NUM_TYPES];
      logic [7:0]  dec_rate [NUM_TYPES];
      logic [31:0] last_adj [NUM_TYPES];
      logic        adj_valid [NUM_TYPES];
      logic [31:0] now_ticks;

      throttle_rsp_type pending_rsp[$];
      int errors;

      function new();
         enable_mask = RST_ENABLE_MASK;
         success_thr = RST_SUCCESS_THR;
         inc_rate    = RST_INCREASE_RATE;
         dec_start   = RST_DECREASE_RATE;
         min_lim     = RST_MIN_LIMIT;
         max_lim     = RST_MAX_LIMIT;
         cooldown    = RST_COOLDOWN;
         init_lim    = RST_INITIAL_LIMIT;
         for (int t = 0; t < NUM_TYPES; t++) begin
            run_cnt[t]     = '0;
            lim[t]         = RST_INITIAL_LIMIT;
            succ_streak[t] = '0;
            fail_streak[t] = '0;
            dec_rate[t]    = RST_DECREASE_RATE;
            last_adj[t]    = '0;
            adj_valid[t]   = 1'b0;
         end
         now_ticks = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_ENABLE_MASK:   enable_mask = data;
            CSR_SUCCESS_THR:   success_thr = data[7:0];
            CSR_INCREASE_RATE: inc_rate = data[9:0];
            CSR_DECREASE_RATE: begin
               dec_start = data[7:0];
               for (int t = 0; t < NUM_TYPES; t++) dec_rate[t] = data[7:0];
            end
            CSR_MIN_LIMIT:     min_lim = data[7:0];
            CSR_MAX_LIMIT:     max_lim = data[7:0];
            CSR_COOLDOWN:      cooldown = data;
            CSR_INITIAL_LIMIT: begin
               init_lim = data[7:0];
               for (int t = 0; t < NUM_TYPES; t++) lim[t] = data[7:0];
            end
            default: ;
         endcase
      endfunction

      function logic [1:0] apply_report(int t, logic ok, logic [10:0] code);
         int cur;
         int nl;
         cur = int'(lim[t]);
         if (!enable_mask[t]) return ADJ_NONE;
         if (adj_valid[t] && (now_ticks - last_adj[t]) < {16'd0, cooldown}) return ADJ_NONE;
         if (ok) begin
            fail_streak[t] = '0;
            if (succ_streak[t] != COUNT_MAX) succ_streak[t]++;
            if (succ_streak[t] >= success_thr && cur < int'(max_lim)) begin
               nl = (cur * int'(inc_rate)) >> 8;
               if (nl > int'(max_lim)) nl = int'(max_lim);
               if (nl > cur) begin
                  lim[t]         = 8'(nl);
                  succ_streak[t] = '0;
                  last_adj[t]    = now_ticks;
                  adj_valid[t]   = 1'b1;
                  return ADJ_RAISE;
               end
            end
            return ADJ_NONE;
         end
         if (code != RATE_CODE) begin
            fail_streak[t] = '0;
            return ADJ_NONE;
         end
         succ_streak[t] = '0;
         if (fail_streak[t] != COUNT_MAX) fail_streak[t]++;
         nl = (cur * int'(dec_rate[t])) >> 8;
         if (nl < int'(min_lim)) nl = int'(min_lim);
         if (nl < cur) begin
            lim[t]       = 8'(nl);
            last_adj[t]  = now_ticks;
            adj_valid[t] = 1'b1;
            if (fail_streak[t] >= FAIL_RUN)
               dec_rate[t] = (int'(dec_rate[t]) >= int'(RATE_FLOOR) + int'(RATE_STEP)) ?
                             dec_rate[t] - RATE_STEP : RATE_FLOOR;
            return ADJ_LOWER;
         end
         return ADJ_NONE;
      endfunction

      function void note_request(logic [1:0] fn, logic [3:0] tt, logic ok, logic [10:0] code);
         throttle_rsp_type e;
         int t;
         t = int'(tt);
         e = '0;
         if (fn == FN_TICK) now_ticks++;
         case (fn)
            FN_REPORT: e.adj = apply_report(t, ok, code);
            FN_DISPATCH: begin
               if (!enable_mask[t] || run_cnt[t] < lim[t]) begin
                  e.granted = 1'b1;
                  if (run_cnt[t] != COUNT_MAX) run_cnt[t]++;
               end
            end
            FN_COMPLETE: if (run_cnt[t] != 8'd0) run_cnt[t]--;
            default: ;
         endcase
         e.cur_limit = lim[t];
         e.run_count = run_cnt[t];
         pending_rsp.push_back(e);
      endfunction

      function void check_response(logic g, logic [7:0] cl, logic [7:0] rc, logic [1:0] adj);
         throttle_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (g !== e.granted) begin
            $error("granted: expected %0d, actual %0d", e.granted, g);
            errors++;
         end
         if (cl !== e.cur_limit) begin
            $error("current_limit: expected %0d, actual %0d", e.cur_limit, cl);
            errors++;
         end
         if (rc !== e.run_count) begin
            $error("running_count: expected %0d, actual %0d", e.run_count, rc);
            errors++;
         end
         if (adj !== e.adj) begin
            $error("adjustment: expected %0d, actual %0d", e.adj, adj);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_func = FN_REPORT;
   logic [3:0]               req_task_type = '0;
   logic                     req_success = 1'b0;
   logic signed [10:0]       req_error_code = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_granted;
   logic [7:0]               rsp_current_limit;
   logic [7:0]               rsp_running_count;
   logic [1:0]               rsp_adjustment;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   throttle_tracker sb = new();
   int  items_sent = 0;
   bit  quiet_tail = 1'b0;
   logic [15:0] reg_plan [8];
   logic [7:0]  reg_which;

   adaptive_concurrency_throttle dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_task_type(req_task_type),
      .req_success(req_success), .req_error_code(req_error_code),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_granted(rsp_granted), .rsp_current_limit(rsp_current_limit),
      .rsp_running_count(rsp_running_count), .rsp_adjustment(rsp_adjustment),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready)
            sb.note_request(req_func, req_task_type, req_success, req_error_code);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_granted, rsp_current_limit, rsp_running_count,
                              rsp_adjustment);
      end
   end

   // response sink: random stall bursts, plus one long hold to back the block up
   initial begin : rsp_side
      int idle_left;
      int hold_left;
      bit hold_done;
      idle_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= 150) begin
            hold_done = 1'b1;
            hold_left = 64;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(1, 16) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_req(input logic [1:0] fn, input logic [3:0] tt, input logic ok,
                           input logic [10:0] code);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= fn;
      req_task_type  <= tt;
      req_success    <= ok;
      req_error_code <= code;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs();
      for (int i = 0; i < 8; i++)
         if (reg_which[i]) write_csr(CSR_IDX_BITS'(i), reg_plan[i]);
      // index past the register file must be ignored
      write_csr(CSR_INITIAL_LIMIT + 4'd1 + 4'($urandom_range(0, 7)),
                16'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // step the clock first so the last accepted request is already in the scoreboard
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [10:0] pick_code();
      case ($urandom_range(0, 5))
         0: return 11'h7FF;
         1: return 11'd0;
         2: return RATE_CODE - 11'd1;
         3: return RATE_CODE + 11'd1;
         4: return 11'd1023;
         default: return 11'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic plan_phase(input int p);
      reg_which = 8'hFF;
      case (p)
         0: reg_plan = '{16'hFFFF, 16'd1, 16'd1023, 16'd255, 16'd1, 16'd255, 16'd0, 16'd4};
         1: reg_plan = '{16'h7FFF, 16'd1, 16'd256, 16'd128, 16'd1, 16'd255, 16'd0, 16'd1};
         2: reg_plan = '{16'hFFFF, 16'd2, 16'd1023, 16'd140, 16'd200, 16'd50, 16'd2, 16'd100};
         3: reg_plan = '{16'hAAAA, 16'd255, 16'd512, 16'd200, 16'd255, 16'd255, 16'd65535,
                         16'd7};
         default: begin
            reg_plan[0] = 16'($urandom_range(0, 65535) | $urandom_range(0, 65535));
            reg_plan[1] = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 255))
                                                      : 16'($urandom_range(1, 4));
            reg_plan[2] = 16'($urandom_range(256, 1023));
            reg_plan[3] = 16'($urandom_range(128, 255));
            reg_plan[4] = 16'($urandom_range(1, 8));
            reg_plan[5] = 16'($urandom_range(16, 255));
            reg_plan[6] = 16'($urandom_range(0, 4));
            reg_plan[7] = 16'($urandom_range(1, 40));
            reg_which   = 8'($urandom_range(1, 255));
         end
      endcase
   endtask

   // mostly streaks on a few neighboring types so limits actually move
   task automatic emit_burst(input logic [3:0] focus);
      int kind;
      int len;
      logic [3:0] t;
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 6);
      t = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                      : focus + 4'($urandom_range(0, 3));
      repeat (len) begin
         case (kind)
            0, 1, 2: send_req(FN_REPORT, t, 1'b1, pick_code());
            3, 4:    send_req(FN_REPORT, t, 1'b0, RATE_CODE);
            5:       send_req(FN_REPORT, t, 1'($urandom_range(0, 1)), pick_code());
            6, 7:    send_req(FN_DISPATCH, t, 1'($urandom_range(0, 1)), pick_code());
            8:       send_req(FN_COMPLETE, t, 1'($urandom_range(0, 1)), pick_code());
            default: send_req(FN_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                              pick_code());
         endcase
      end
   endtask

   initial begin : stimulus
      int start;
      logic [3:0] focus;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: throttling off everywhere
      send_req(FN_DISPATCH, 4'd0, 1'b0, 11'd0);
      send_req(FN_DISPATCH, 4'd0, 1'b0, 11'd0);
      send_req(FN_COMPLETE, 4'd0, 1'b0, 11'd0);
      send_req(FN_COMPLETE, 4'd0, 1'b0, 11'd0);
      send_req(FN_COMPLETE, 4'd0, 1'b0, 11'd0);
      send_req(FN_REPORT, 4'd0, 1'b1, 11'd0);
      send_req(FN_REPORT, 4'd0, 1'b0, RATE_CODE);
      send_req(FN_TICK, 4'd15, 1'b1, 11'h7FF);
      drain();

      plan_phase(0);
      program_regs();
      repeat (5) send_req(FN_DISPATCH, 4'd3, 1'b0, 11'd0);
      send_req(FN_COMPLETE, 4'd3, 1'b0, 11'd0);
      send_req(FN_REPORT, 4'd3, 1'b1, 11'd0);
      send_req(FN_REPORT, 4'd3, 1'b1, 11'd0);
      repeat (4) send_req(FN_REPORT, 4'd3, 1'b0, RATE_CODE);
      send_req(FN_REPORT, 4'd3, 1'b0, 11'h7FF);
      send_req(FN_REPORT, 4'd3, 1'b0, 11'd1023);
      send_req(FN_REPORT, 4'd3, 1'b0, 11'd0);
      send_req(FN_REPORT, 4'd3, 1'b0, RATE_CODE - 11'd1);
      send_req(FN_REPORT, 4'd3, 1'b0, RATE_CODE);
      send_req(FN_REPORT, 4'd15, 1'b1, 11'd0);
      send_req(FN_TICK, 4'd15, 1'b0, 11'd0);
      send_req(FN_COMPLETE, 4'd15, 1'b0, 11'd0);
      drain();

      for (int p = 1; p <= NUM_PHASES; p++) begin
         plan_phase(p);
         program_regs();
         if (p == NUM_PHASES) quiet_tail = 1'b1;
         if (p == 1) begin
            // running count saturates on a disabled type
            repeat (FLOOD_ITEMS) send_req(FN_DISPATCH, 4'd15, 1'b1, 11'd0);
            send_req(FN_COMPLETE, 4'd15, 1'b0, 11'd0);
         end
         focus = 4'($urandom_range(0, 15));
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) emit_burst(focus);
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
